>>> hw/rtl/assert_macros.svh
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define OWBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("one_wire_bus_master check failed");

// Next-cycle implication, ignored while reset is held.
`define OWBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("one_wire_bus_master check failed");

`endif

>>> hw/rtl/owbm_pkg.sv
`timescale 1ns / 1ps

package owbm_pkg;

    localparam int unsigned TICK_W = 10;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW     = 3'd0,
        CFG_PRESENCE_WAIT = 3'd1,
        CFG_PRESENCE_TAIL = 3'd2,
        CFG_READ_SAMPLE   = 3'd3,
        CFG_SLOT          = 3'd4
    } t_cfg_index;

    localparam logic [TICK_W-1:0] RESET_LOW_DEFAULT     = 10'd480;
    localparam logic [TICK_W-1:0] PRESENCE_WAIT_DEFAULT = 10'd70;
    localparam logic [TICK_W-1:0] PRESENCE_TAIL_DEFAULT = 10'd410;
    localparam logic [TICK_W-1:0] READ_SAMPLE_DEFAULT   = 10'd9;
    localparam logic [TICK_W-1:0] SLOT_DEFAULT          = 10'd60;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] write_data;
        logic       line_level;
    } t_in_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } t_out_item;

endpackage

>>> hw/rtl/one_wire_bus_master.sv
`timescale 1ns / 1ps
// One-wire bus master sequencer, advanced by one request per microsecond tick.
// Input channel (i_in_valid / o_in_ready / i_in_data): each request is one tick
// carrying the sampled bus level and an opcode (tick only, bus reset, write
// byte, read byte). A command is taken only while idle; otherwise it is
// flagged as rejected in that tick's result.
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one result
// per request: drive_low, busy, done, presence, read byte, rejected.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data): five
// 10-bit timing registers, always ready; write them only while idle.
// Result: each result is registered when its request is accepted.
// Throughput: one request per cycle while the output is not stalled; the sequencer state and the result
// register are updated in the same cycle as the accept.
// Stall: the result register holds until taken; a new request is accepted in
// the cycle the held result is taken, so a stalled receiver stops the input.
// Reset: the sequencer returns to idle, presence clears, the timing registers
// load their defaults and no result is pending.
module one_wire_bus_master (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  owbm_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output owbm_pkg::t_out_item          o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [owbm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [owbm_pkg::TICK_W-1:0]  i_cfg_data
);
    import owbm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_RLOW    = 4'd1,
        PH_RWAIT   = 4'd2,
        PH_RTAIL   = 4'd3,
        PH_WPULSE  = 4'd4,
        PH_WSLOT   = 4'd5,
        PH_RDPULSE = 4'd6,
        PH_RDWAIT  = 4'd7,
        PH_RDSLOT  = 4'd8
    } t_phase;

    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        at_least_one = (v == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : v;
    endfunction

    logic [TICK_W-1:0] r_reset_low;
    logic [TICK_W-1:0] r_presence_wait;
    logic [TICK_W-1:0] r_presence_tail;
    logic [TICK_W-1:0] r_read_sample;
    logic [TICK_W-1:0] r_slot;

    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [2:0]        r_bit, n_bit;
    logic [7:0]        r_shift, n_shift;
    logic              r_presence, n_presence;

    logic              r_out_valid;
    t_out_item         r_out_data, n_out_data;

    logic              in_accept;
    logic              cfg_accept;
    t_opcode           op;
    t_phase            ph;
    logic              done;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign op          = t_opcode'(i_in_data.opcode);

    always_comb begin
        n_tick     = r_tick;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_presence = r_presence;
        n_out_data = '0;
        done       = 1'b0;
        ph         = r_phase;

        if (ph != PH_IDLE) begin
            n_out_data.rejected = (op != OP_TICK);
        end else if (op != OP_TICK) begin
            n_tick = '0;
            n_bit  = '0;
            unique case (op)
                OP_RESET: begin
                    ph = PH_RLOW;
                end
                OP_WRITE: begin
                    n_shift = i_in_data.write_data;
                    ph      = PH_WPULSE;
                end
                default: begin
                    n_shift = '0;
                    ph      = PH_RDPULSE;
                end
            endcase
        end

        if (ph != PH_IDLE) begin
            n_out_data.busy_res = 1'b1;
            unique case (ph)
                PH_RLOW: begin
                    n_out_data.drive_low = 1'b1;
                    n_tick = n_tick + 1'b1;
                    if (n_tick >= at_least_one(r_reset_low)) begin
                        ph     = PH_RWAIT;
                        n_tick = '0;
                    end
                end
                PH_RWAIT: begin
                    n_tick = n_tick + 1'b1;
                    if (n_tick >= at_least_one(r_presence_wait)) begin
                        n_presence = !i_in_data.line_level;
                        n_tick     = '0;
                        if (r_presence_tail == '0) begin
                            done = 1'b1;
                        end else begin
                            ph = PH_RTAIL;
                        end
                    end
                end
                PH_RTAIL: begin
                    n_tick = n_tick + 1'b1;
                    if (n_tick >= r_presence_tail) begin
                        done = 1'b1;
                    end
                end
                PH_WPULSE: begin
                    n_out_data.drive_low = 1'b1;
                    ph     = PH_WSLOT;
                    n_tick = '0;
                end
                PH_WSLOT: begin
                    n_out_data.drive_low = !n_shift[0];
                    n_tick = n_tick + 1'b1;
                    if (n_tick >= at_least_one(r_slot)) begin
                        n_shift = {1'b0, n_shift[7:1]};
                        n_tick  = '0;
                        if (n_bit == 3'd7) begin
                            done = 1'b1;
                        end else begin
                            n_bit = n_bit + 1'b1;
                            ph    = PH_WPULSE;
                        end
                    end
                end
                PH_RDPULSE: begin
                    n_out_data.drive_low = 1'b1;
                    ph     = PH_RDWAIT;
                    n_tick = '0;
                end
                PH_RDWAIT: begin
                    n_tick = n_tick + 1'b1;
                    if (n_tick >= at_least_one(r_read_sample)) begin
                        n_shift = {i_in_data.line_level, n_shift[7:1]};
                        ph      = PH_RDSLOT;
                        n_tick  = '0;
                    end
                end
                PH_RDSLOT: begin
                    n_tick = n_tick + 1'b1;
                    if (n_tick >= at_least_one(r_slot)) begin
                        n_tick = '0;
                        if (n_bit == 3'd7) begin
                            done                 = 1'b1;
                            n_out_data.read_data = n_shift;
                        end else begin
                            n_bit = n_bit + 1'b1;
                            ph    = PH_RDPULSE;
                        end
                    end
                end
                default: begin
                    ph = PH_IDLE;
                end
            endcase
            if (done) begin
                ph     = PH_IDLE;
                n_tick = '0;
                n_bit  = '0;
            end
        end

        n_out_data.done_res = done;
        n_out_data.presence = n_presence;
        n_phase             = ph;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low     <= RESET_LOW_DEFAULT;
            r_presence_wait <= PRESENCE_WAIT_DEFAULT;
            r_presence_tail <= PRESENCE_TAIL_DEFAULT;
            r_read_sample   <= READ_SAMPLE_DEFAULT;
            r_slot          <= SLOT_DEFAULT;
            r_phase         <= PH_IDLE;
            r_tick          <= '0;
            r_bit           <= '0;
            r_shift         <= '0;
            r_presence      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (cfg_accept) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_RESET_LOW:     r_reset_low     <= i_cfg_data;
                    CFG_PRESENCE_WAIT: r_presence_wait <= i_cfg_data;
                    CFG_PRESENCE_TAIL: r_presence_tail <= i_cfg_data;
                    CFG_READ_SAMPLE:   r_read_sample   <= i_cfg_data;
                    CFG_SLOT:          r_slot          <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_presence  <= n_presence;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

>>> hw/rtl/owbm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module owbm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input owbm_pkg::t_out_item o_out_data
);
    import owbm_pkg::*;

    `OWBM_ASSERT_NOW(a_done_busy, i_clk, i_rst_n, o_out_valid && o_out_data.done_res, o_out_data.busy_res)
    `OWBM_ASSERT_NOW(a_drive_busy, i_clk, i_rst_n, o_out_valid && o_out_data.drive_low, o_out_data.busy_res)
    `OWBM_ASSERT_NOW(a_rdata_done, i_clk, i_rst_n, o_out_valid && (o_out_data.read_data != 8'd0), o_out_data.done_res)
    `OWBM_ASSERT_NOW(a_ready_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    `OWBM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
